[rtl/tff_pkg.sv]
// tff_pkg: shared types and constants for the TLV field finder.
// Depends on nothing; imported by the parser, the result queue and the top level.
package tff_pkg;

   // Entry layout
   localparam int unsigned HEADER_BYTES = 6;
   localparam int unsigned WORD_BYTES   = 8;
   localparam logic [31:0] ONE_BYTE_LEN = 32'd1;
   localparam logic [2:0]  HDR_LAST     = 3'(HEADER_BYTES - 1);
   localparam logic [31:0] WORD_LEN     = 32'(WORD_BYTES);

   // Result queue depth (room for two results per transfer)
   localparam int unsigned RQ_DEPTH = 4;
   localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);
   localparam int unsigned RQ_CW    = $clog2(RQ_DEPTH + 1);

   // Check modes
   localparam logic [1:0] MODE_RAW  = 2'd0;
   localparam logic [1:0] MODE_BYTE = 2'd1;
   localparam logic [1:0] MODE_WORD = 2'd2;
   localparam logic [1:0] MODE_STR  = 2'd3;

   // Status codes
   localparam logic [1:0] ST_FOUND  = 2'd0;
   localparam logic [1:0] ST_ABSENT = 2'd1;
   localparam logic [1:0] ST_BAD    = 2'd2;

   // Result kinds
   localparam logic KIND_VALUE  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  value_byte;
      logic [1:0]  status;
      logic [31:0] value_length;
      logic [63:0] value_word;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;   // results pushed this cycle, 0..2
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

[rtl/tff_parser.sv]
// tff_parser: TLV header collection, tag match, value pass-through and final status.
// Depends on tff_pkg; feeds up to two results per transfer into tff_rsp_queue.
module tff_parser
   import tff_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  data_byte,
   input  logic        last,
   input  logic        empty_payload,
   input  logic [15:0] wanted_tag,
   input  logic [1:0]  check_mode,
   input  logic [31:0] string_capacity,
   output push_type    push
);

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_SKIP   = 2'd1,
      PH_PASS   = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  hcount_ff, hcount_in;
   logic [15:0] tag_ff, tag_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] left_ff, left_in;
   logic [31:0] mlen_ff, mlen_in;
   logic [63:0] accum_ff, accum_in;
   logic        zero_ff, zero_in;

   logic [31:0] full_len;
   logic [1:0]  len_lane;
   logic [31:0] pass_idx;
   logic        emit_val;
   logic        ok;
   logic [1:0]  st;
   rsp_type     val_rsp;
   rsp_type     stat_rsp;

   // Next state, value result and status result
   always_comb begin
      phase_in = phase_ff;
      hcount_in = hcount_ff;
      tag_in = tag_ff;
      len_in = len_ff;
      left_in = left_ff;
      mlen_in = mlen_ff;
      accum_in = accum_ff;
      zero_in = zero_ff;
      emit_val = 1'b0;
      val_rsp = '0;
      stat_rsp = '0;
      ok = 1'b1;
      st = ST_ABSENT;
      len_lane = 2'(hcount_ff - 3'd2);
      full_len = {data_byte, len_ff[23:0]};
      pass_idx = mlen_ff - left_ff;

      // Consume one byte
      if (accept && !empty_payload) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (hcount_ff < 3'd2) begin
                  if (hcount_ff[0]) tag_in = {data_byte, tag_ff[7:0]};
                  else              tag_in = {tag_ff[15:8], data_byte};
               end else begin
                  len_in[8*len_lane +: 8] = data_byte;
               end
               hcount_in = hcount_ff + 3'd1;
               if (hcount_ff == HDR_LAST) begin
                  hcount_in = '0;
                  left_in = full_len;
                  if (tag_ff == wanted_tag) begin
                     mlen_in = full_len;
                     accum_in = '0;
                     zero_in = 1'b0;
                     phase_in = (full_len == '0) ? PH_DONE : PH_PASS;
                  end else begin
                     phase_in = (full_len == '0) ? PH_HEADER : PH_SKIP;
                  end
                  tag_in = '0;
                  len_in = '0;
               end
            end
            PH_SKIP: begin
               left_in = left_ff - 32'd1;
               if (left_ff == 32'd1) phase_in = PH_HEADER;
            end
            PH_PASS: begin
               if (pass_idx < WORD_LEN) accum_in[8*pass_idx[2:0] +: 8] = data_byte;
               if (data_byte == 8'd0) zero_in = 1'b1;
               emit_val = 1'b1;
               val_rsp.result_kind = KIND_VALUE;
               val_rsp.value_byte = data_byte;
               left_in = left_ff - 32'd1;
               if (left_ff == 32'd1) phase_in = PH_DONE;
            end
            PH_DONE: begin
               // drop bytes after the match
            end
            default: begin
            end
         endcase
      end

      // Final status on the last transfer, then return to reset state
      if (phase_in == PH_DONE) begin
         if (check_mode == MODE_BYTE && mlen_in != ONE_BYTE_LEN) ok = 1'b0;
         if (check_mode == MODE_WORD && mlen_in != WORD_LEN) ok = 1'b0;
         if (check_mode == MODE_STR && (mlen_in >= string_capacity || zero_in)) ok = 1'b0;
         st = ok ? ST_FOUND : ST_BAD;
      end else if (phase_in == PH_HEADER && hcount_in == '0) begin
         st = ST_ABSENT;
      end else begin
         st = ST_BAD;
      end
      stat_rsp.result_kind = KIND_STATUS;
      stat_rsp.status = st;
      if (st == ST_FOUND) begin
         stat_rsp.value_length = mlen_in;
         if (check_mode == MODE_BYTE)      stat_rsp.value_word = {56'd0, accum_in[7:0]};
         else if (check_mode == MODE_WORD) stat_rsp.value_word = accum_in;
      end

      if (accept && last) begin
         phase_in = PH_HEADER;
         hcount_in = '0;
         tag_in = '0;
         len_in = '0;
         left_in = '0;
         mlen_in = '0;
         accum_in = '0;
         zero_in = 1'b0;
      end
   end

   // Hand results to the queue in order: value byte first, status second
   always_comb begin
      push.count = {1'b0, emit_val} + {1'b0, accept && last};
      push.first = emit_val ? val_rsp : stat_rsp;
      push.second = stat_rsp;
   end

   // Hold parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         hcount_ff <= '0;
         tag_ff <= '0;
         len_ff <= '0;
         left_ff <= '0;
         mlen_ff <= '0;
         accum_ff <= '0;
         zero_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         hcount_ff <= hcount_in;
         tag_ff <= tag_in;
         len_ff <= len_in;
         left_ff <= left_in;
         mlen_ff <= mlen_in;
         accum_ff <= accum_in;
         zero_ff <= zero_in;
      end
   end

   // A final status leaves the parser in its reset state
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && last |=> phase_ff == PH_HEADER && hcount_ff == '0 && mlen_ff == '0)
      else $error("parser state not cleared after final status");

   // Header bytes are only counted while collecting a header
   a_hcount_in_header: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_HEADER |-> hcount_ff == '0)
      else $error("header count nonzero outside header phase");

   // Passing or skipping always has bytes still to come
   a_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PASS || phase_ff == PH_SKIP |-> left_ff != '0)
      else $error("value phase with no bytes left");

endmodule

[rtl/tff_rsp_queue.sv]
// tff_rsp_queue: small result queue that takes up to two results per cycle.
// Depends on tff_pkg; drives the rsp_ channel of the top level.
module tff_rsp_queue
   import tff_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   rsp_type             mem_ff [RQ_DEPTH];
   logic [RQ_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [RQ_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [RQ_CW-1:0]    count_ff, count_in;
   logic [RQ_AW-1:0]    wr_next;
   logic                pop;

   assign wr_next = wr_ptr_ff + RQ_AW'(1);
   assign pop = rsp_valid && rsp_ready;
   assign rsp_valid = count_ff != '0;
   assign rsp_data = mem_ff[rd_ptr_ff];
   assign room = count_ff <= RQ_CW'(RQ_DEPTH - 2);

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff + RQ_AW'(push.count);
      rd_ptr_in = rd_ptr_ff + RQ_AW'(pop);
      count_in = count_ff + RQ_CW'(push.count) - RQ_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Store pushed results
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) mem_ff[wr_ptr_ff] <= push.first;
      if (push.count == 2'd2) mem_ff[wr_next] <= push.second;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) + 32'(push.count) <= 32'(RQ_DEPTH))
      else $error("result queue overflow");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      pop && push.count == 2'd0 |=> count_ff == $past(count_ff) - RQ_CW'(1))
      else $error("occupancy did not drop on transfer out");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      RQ_AW'(wr_ptr_ff - rd_ptr_ff) == RQ_AW'(count_ff) || count_ff == RQ_CW'(RQ_DEPTH))
      else $error("queue pointers disagree with occupancy");

endmodule

[rtl/tlv_field_finder_top.sv]
// TLV field finder: finds the first entry with a wanted tag and streams its value.
// Results: a transfer's results are written into the result queue and offered on rsp_ once earlier results have left.
// Throughput: one payload byte per cycle; a value byte on the last byte gives two
// results, and req_ready drops while the four-entry result queue has under two free slots.
// Reset: synchronous, active high; clears the parse state and empties the result queue.
// Depends on tff_pkg, tff_parser and tff_rsp_queue.
module tlv_field_finder_top
   import tff_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   input  logic        req_empty_payload,
   input  logic [15:0] req_wanted_tag,
   input  logic [1:0]  req_check_mode,
   input  logic [31:0] req_string_capacity,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_value_byte,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_value_length,
   output logic [63:0] rsp_value_word
);

   push_type push;
   rsp_type  rsp_data;
   logic     room;

   assign req_ready = room;

   tff_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .accept          (req_valid && req_ready),
      .data_byte       (req_data_byte),
      .last            (req_last),
      .empty_payload   (req_empty_payload),
      .wanted_tag      (req_wanted_tag),
      .check_mode      (req_check_mode),
      .string_capacity (req_string_capacity),
      .push            (push)
   );

   tff_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Split the result record onto its ports
   assign rsp_result_kind = rsp_data.result_kind;
   assign rsp_value_byte = rsp_data.value_byte;
   assign rsp_status = rsp_data.status;
   assign rsp_value_length = rsp_data.value_length;
   assign rsp_value_word = rsp_data.value_word;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking testbench for tlv_field_finder_top (TLV tag search, one byte per transfer).
// Depends on tff_pkg and the RTL; a local scan model predicts value bytes and final status.
module tb_top;
   import tff_pkg::*;

   localparam int CLK_PERIOD     = 4;
   localparam int RESET_CYCLES   = 8;
   localparam int RANDOM_ITEMS   = 650;
   localparam int LONG_HOLD      = 200;
   localparam int HOLD_AT        = 200;
   localparam int PAUSE_AT       = 420;
   localparam int DRAIN_CYCLES   = 16;
   localparam int TIMEOUT_CYCLES = 400_000;
   localparam int MAX_REPORTS    = 100;

   typedef enum logic [1:0] {
      SCAN_HEADER,
      SCAN_SKIP,
      SCAN_PASS,
      SCAN_DONE
   } scan_phase_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last;
      logic        empty_payload;
      logic [15:0] wanted_tag;
      logic [1:0]  check_mode;
      logic [31:0] string_capacity;
   } finder_req_type;

   typedef struct {
      finder_req_type item;
      bit             typed;
      rsp_type        status_rsp;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_last;
   logic        req_empty_payload;
   logic [15:0] req_wanted_tag;
   logic [1:0]  req_check_mode;
   logic [31:0] req_string_capacity;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_result_kind;
   logic [7:0]  rsp_value_byte;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_value_length;
   logic [63:0] rsp_value_word;

   tlv_field_finder_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_last            (req_last),
      .req_empty_payload   (req_empty_payload),
      .req_wanted_tag      (req_wanted_tag),
      .req_check_mode      (req_check_mode),
      .req_string_capacity (req_string_capacity),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_value_byte      (rsp_value_byte),
      .rsp_status          (rsp_status),
      .rsp_value_length    (rsp_value_length),
      .rsp_value_word      (rsp_value_word)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Scan model state
   scan_phase_type scan_phase;
   logic [2:0]  hdr_count;
   logic [15:0] tag_acc;
   logic [31:0] len_acc;
   logic [31:0] bytes_remaining;
   logic [31:0] match_len;
   logic [63:0] word_acc;
   logic        zero_byte_seen;

   rsp_type          expected_rsp_q[$];
   directed_row_type directed_rows[$];
   int            mismatch_count = 0;
   int            live_items = 0;
   int            burst_left = 0;
   bit            hold_request = 0;
   int            hold_left = 0;
   int            stall_style = 0;
   int            stall_left = 0;
   int            rx_tick = 0;

   function automatic void clear_scan();
      scan_phase      = SCAN_HEADER;
      hdr_count       = '0;
      tag_acc         = '0;
      len_acc         = '0;
      bytes_remaining = '0;
      match_len       = '0;
      word_acc        = '0;
      zero_byte_seen  = 1'b0;
   endfunction

   // Advance the scan model by one transfer and queue the results it causes
   function automatic void predict_scan(finder_req_type it);
      rsp_type     r;
      logic [31:0] idx;
      int          pos;
      logic        check_ok;
      if (!it.empty_payload) begin
         case (scan_phase)
            SCAN_HEADER: begin
               pos = int'(hdr_count);
               if (pos < 2) tag_acc[pos*8 +: 8] = it.data_byte;
               else len_acc[(pos-2)*8 +: 8] = it.data_byte;
               if (hdr_count == HDR_LAST) begin
                  hdr_count = '0;
                  bytes_remaining = len_acc;
                  if (tag_acc == it.wanted_tag) begin
                     match_len = len_acc;
                     word_acc = '0;
                     zero_byte_seen = 1'b0;
                     scan_phase = (len_acc == 0) ? SCAN_DONE : SCAN_PASS;
                  end else begin
                     scan_phase = (len_acc == 0) ? SCAN_HEADER : SCAN_SKIP;
                  end
                  tag_acc = '0;
                  len_acc = '0;
               end else begin
                  hdr_count = hdr_count + 3'd1;
               end
            end
            SCAN_SKIP: begin
               bytes_remaining = bytes_remaining - 1;
               if (bytes_remaining == 0) scan_phase = SCAN_HEADER;
            end
            SCAN_PASS: begin
               idx = match_len - bytes_remaining;
               if (idx < WORD_LEN) word_acc[idx*8 +: 8] = it.data_byte;
               if (it.data_byte == 8'h00) zero_byte_seen = 1'b1;
               r = '0;
               r.result_kind = KIND_VALUE;
               r.value_byte = it.data_byte;
               expected_rsp_q.push_back(r);
               bytes_remaining = bytes_remaining - 1;
               if (bytes_remaining == 0) scan_phase = SCAN_DONE;
            end
            default: ;
         endcase
      end

      if (it.last) begin
         r = '0;
         r.result_kind = KIND_STATUS;
         if (scan_phase == SCAN_DONE) begin
            check_ok = 1'b1;
            case (it.check_mode)
               MODE_BYTE: check_ok = (match_len == ONE_BYTE_LEN);
               MODE_WORD: check_ok = (match_len == WORD_LEN);
               MODE_STR:  check_ok = (match_len < it.string_capacity) && !zero_byte_seen;
               default: ;
            endcase
            if (check_ok) begin
               r.status = ST_FOUND;
               r.value_length = match_len;
               if (it.check_mode == MODE_BYTE) r.value_word = {56'h0, word_acc[7:0]};
               else if (it.check_mode == MODE_WORD) r.value_word = word_acc;
            end else begin
               r.status = ST_BAD;
            end
         end else if (scan_phase == SCAN_HEADER && hdr_count == 0) begin
            r.status = ST_ABSENT;
         end else begin
            r.status = ST_BAD;
         end
         expected_rsp_q.push_back(r);
         clear_scan();
      end
   endfunction

   function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      end
   endfunction

   // Compare each result transfer against the oldest expectation
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: unexpected result: expected none, actual kind %0h byte %0h status %0h",
                        $time, rsp_result_kind, rsp_value_byte, rsp_status);
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("result_kind", 64'(want.result_kind), 64'(rsp_result_kind));
            check_field("value_byte", 64'(want.value_byte), 64'(rsp_value_byte));
            check_field("status", 64'(want.status), 64'(rsp_status));
            check_field("value_length", 64'(want.value_length), 64'(rsp_value_length));
            check_field("value_word", want.value_word, rsp_value_word);
         end
      end
   end

   // Result side: long hold on request, otherwise a rotating stall pattern
   always @(posedge clock) begin
      rx_tick++;
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (hold_request) begin
         hold_request = 0;
         hold_left = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 80);
         end
         stall_left--;
         case (stall_style)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= (rx_tick % 4) != 3;
            2: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Offer one item in bursts with random gaps; predict on transfer
   task automatic send_item(finder_req_type it, bit typed, rsp_type status_rsp);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid           <= 1'b1;
      req_data_byte       <= it.data_byte;
      req_last            <= it.last;
      req_empty_payload   <= it.empty_payload;
      req_wanted_tag      <= it.wanted_tag;
      req_check_mode      <= it.check_mode;
      req_string_capacity <= it.string_capacity;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_scan(it);
      if (typed) expected_rsp_q[expected_rsp_q.size() - 1] = status_rsp;
      if (!it.empty_payload || it.last) live_items++;
   endtask

   function automatic void add_row(logic [7:0] data, logic last, logic empty, logic [15:0] tag,
                                   logic [1:0] mode, logic [31:0] cap, bit typed,
                                   logic [1:0] st, logic [31:0] len, logic [63:0] word);
      directed_row_type row;
      row.item = '{data_byte: data, last: last, empty_payload: empty, wanted_tag: tag,
                   check_mode: mode, string_capacity: cap};
      row.typed = typed;
      row.status_rsp = '{result_kind: KIND_STATUS, value_byte: 8'h00, status: st,
                         value_length: len, value_word: word};
      directed_rows.push_back(row);
   endfunction

   function automatic logic [7:0] value_byte_pick(bit zero_free);
      if (zero_free) return 8'($urandom_range(1, 255));
      return ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
   endfunction

   // Build one payload of TLV entries, mostly well formed, and transfer it
   task automatic send_random_payload();
      logic [7:0]  bytes_q[$];
      logic [15:0] want;
      logic [15:0] entry_tag;
      logic [1:0]  mode;
      logic [31:0] cap;
      logic [31:0] entry_len;
      logic [31:0] planted_len;
      int          n_entries;
      int          n_value;
      int          cut;
      bit          have_match;
      bit          zero_free;
      bit          drift_tag;
      bit          trailing_empty;
      finder_req_type it;
      rsp_type     none;

      none = '0;
      case ($urandom_range(0, 3))
         0: want = 16'h0000;
         1: want = 16'hFFFF;
         default: want = 16'($urandom);
      endcase
      mode = 2'($urandom_range(0, 3));
      zero_free = ($urandom_range(0, 3) != 0);
      drift_tag = ($urandom_range(0, 9) == 0);
      trailing_empty = ($urandom_range(0, 9) == 0);
      have_match = 0;
      planted_len = 32'($urandom_range(0, 12));

      if ($urandom_range(0, 9) == 0) begin
         // noise: random bytes with no structure
         repeat ($urandom_range(1, 12)) bytes_q.push_back(8'($urandom));
      end else begin
         n_entries = $urandom_range(0, 3);
         for (int e = 0; e < n_entries; e++) begin
            if ($urandom_range(0, 2) == 0) entry_tag = want;
            else if ($urandom_range(0, 1) == 0) entry_tag = want ^ 16'(1 << $urandom_range(0, 15));
            else entry_tag = 16'($urandom);
            if (entry_tag == want && !have_match) begin
               case (mode)
                  MODE_BYTE: entry_len = ($urandom_range(0, 4) != 0) ? 32'd1
                                                                     : 32'($urandom_range(0, 3));
                  MODE_WORD: entry_len = ($urandom_range(0, 4) != 0) ? 32'd8
                                                                     : 32'($urandom_range(0, 10));
                  default:   entry_len = 32'($urandom_range(0, 10));
               endcase
               have_match = 1;
               planted_len = entry_len;
            end else begin
               entry_len = ($urandom_range(0, 5) == 0) ? 32'd0 : 32'($urandom_range(1, 10));
            end
            // a huge length on the final entry truncates its value
            if (e == n_entries - 1 && $urandom_range(0, 7) == 0)
               entry_len = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
            bytes_q.push_back(entry_tag[7:0]);
            bytes_q.push_back(entry_tag[15:8]);
            for (int k = 0; k < 4; k++) bytes_q.push_back(entry_len[k*8 +: 8]);
            n_value = (entry_len > 12) ? $urandom_range(0, 5) : int'(entry_len);
            for (int k = 0; k < n_value; k++) bytes_q.push_back(value_byte_pick(zero_free));
         end
         // broken payload: cut it short anywhere
         if ($urandom_range(0, 6) == 0 && bytes_q.size() > 1) begin
            cut = $urandom_range(1, bytes_q.size() - 1);
            while (bytes_q.size() > cut) void'(bytes_q.pop_back());
         end
      end

      case ($urandom_range(0, 4))
         0: cap = 32'h0;
         1: cap = planted_len;
         2: cap = planted_len + 32'd1;
         3: cap = 32'hFFFF_FFFF;
         default: cap = $urandom;
      endcase
      if (bytes_q.size() == 0) trailing_empty = 1;

      foreach (bytes_q[i]) begin
         if ($urandom_range(0, 19) == 0) begin
            it = '{data_byte: 8'($urandom), last: 1'b0, empty_payload: 1'b1,
                   wanted_tag: 16'($urandom), check_mode: 2'($urandom),
                   string_capacity: $urandom};
            send_item(it, 0, none);
         end
         it.data_byte = bytes_q[i];
         it.empty_payload = 1'b0;
         it.last = (i == bytes_q.size() - 1) && !trailing_empty;
         it.wanted_tag = (drift_tag && $urandom_range(0, 1) == 0) ? 16'($urandom) : want;
         it.check_mode = it.last ? mode : 2'($urandom);
         it.string_capacity = it.last ? cap : $urandom;
         send_item(it, 0, none);
      end
      if (trailing_empty) begin
         it = '{data_byte: 8'($urandom), last: 1'b1, empty_payload: 1'b1, wanted_tag: want,
                check_mode: mode, string_capacity: cap};
         send_item(it, 0, none);
      end
   endtask

   initial begin
      bit hold_done;
      bit pause_done;
      hold_done = 0;
      pause_done = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_last = 1'b0;
      req_empty_payload = 1'b0;
      req_wanted_tag = '0;
      req_check_mode = MODE_RAW;
      req_string_capacity = '0;
      rsp_ready = 1'b0;
      clear_scan();

      // empty payload: nothing to find
      add_row(8'h00, 1, 1, 16'h0000, MODE_RAW, 32'h0, 1, ST_ABSENT, 32'd0, 64'h0);
      // one-byte entry, matched and checked; an ignored empty transfer sits in the header
      add_row(8'h34, 0, 0, 16'h1234, MODE_BYTE, 32'h0, 0, ST_FOUND, 32'd0, 64'h0);
      add_row(8'hFF, 0, 1, 16'h1234, MODE_STR, 32'hFFFF_FFFF, 0, ST_FOUND, 32'd0, 64'h0);
      add_row(8'h12, 0, 0, 16'h1234, MODE_BYTE, 32'h0, 0, ST_FOUND, 32'd0, 64'h0);
      add_row(8'h01, 0, 0, 16'h1234, MODE_BYTE, 32'h0, 0, ST_FOUND, 32'd0, 64'h0);
      add_row(8'h00, 0, 0, 16'h1234, MODE_BYTE, 32'h0, 0, ST_FOUND, 32'd0, 64'h0);
      add_row(8'h00, 0, 0, 16'h1234, MODE_BYTE, 32'h0, 0, ST_FOUND, 32'd0, 64'h0);
      add_row(8'h00, 0, 0, 16'h1234, MODE_BYTE, 32'h0, 0, ST_FOUND, 32'd0, 64'h0);
      add_row(8'hAB, 1, 0, 16'h1234, MODE_BYTE, 32'h0, 1, ST_FOUND, 32'd1, 64'hAB);
      // truncated header, all-ones bytes
      add_row(8'hFF, 0, 0, 16'hFFFF, MODE_WORD, 32'hFFFF_FFFF, 0, ST_BAD, 32'd0, 64'h0);
      add_row(8'hFF, 0, 0, 16'hFFFF, MODE_WORD, 32'hFFFF_FFFF, 0, ST_BAD, 32'd0, 64'h0);
      add_row(8'hFF, 1, 0, 16'hFFFF, MODE_WORD, 32'hFFFF_FFFF, 1, ST_BAD, 32'd0, 64'h0);
      // zero-length match in string mode, capacity one
      for (int k = 0; k < 5; k++)
         add_row(8'h00, 0, 0, 16'h0000, MODE_STR, 32'd1, 0, ST_FOUND, 32'd0, 64'h0);
      add_row(8'h00, 1, 0, 16'h0000, MODE_STR, 32'd1, 1, ST_FOUND, 32'd0, 64'h0);
      // zero-length miss, then an empty last transfer closes the payload
      add_row(8'h5A, 0, 0, 16'h0001, MODE_RAW, 32'h0, 0, ST_ABSENT, 32'd0, 64'h0);
      add_row(8'hA5, 0, 0, 16'h0001, MODE_RAW, 32'h0, 0, ST_ABSENT, 32'd0, 64'h0);
      for (int k = 0; k < 4; k++)
         add_row(8'h00, 0, 0, 16'h0001, MODE_RAW, 32'h0, 0, ST_ABSENT, 32'd0, 64'h0);
      add_row(8'h00, 1, 1, 16'h0001, MODE_RAW, 32'h0, 1, ST_ABSENT, 32'd0, 64'h0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].status_rsp);

      live_items = 0;
      while (live_items < RANDOM_ITEMS) begin
         // hold the result side off while transfers keep coming
         if (!hold_done && live_items >= HOLD_AT) begin
            hold_request = 1;
            hold_done = 1;
         end
         // stop offering until every result is back
         if (!pause_done && live_items >= PAUSE_AT) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (expected_rsp_q.size() != 0);
            pause_done = 1;
         end
         send_random_payload();
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rsp_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("%0t: timeout, %0d results still expected", $time, expected_rsp_q.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
